// ===== src/egcd_pkg.sv =====
// Package for the extended gcd unit: widths, word types, shared limits.
`default_nettype none
package egcd_pkg;
	localparam int OpWidth   = 63;
	localparam int CoefWidth = 64;
	localparam int DefOperandWidth = 64;
	localparam int MaxSteps  = 128;

	typedef struct packed {
		logic [OpWidth-1:0] first_operand;
		logic [OpWidth-1:0] second_operand;
	} egcd_in_t;

	typedef struct packed {
		logic [CoefWidth-1:0] coeff_first;
		logic [CoefWidth-1:0] coeff_second;
		logic                 zero_divisor_error;
	} egcd_out_t;
endpackage
`default_nettype wire

// ===== src/extended_gcd_bezout_unit.sv =====
// Top level of the extended gcd unit: sequencer over a serial divider and two serial MACs.
//  channel | dir | handshake        | word
//  in      | in  | in_valid/in_ready | egcd_in_t
//  out     | out | out_valid/out_ready | egcd_out_t
// In each Euclid step the divider produces one quotient bit per cycle, then both
// coefficient MACs take one quotient bit per cycle.
// An item runs at most MaxSteps (128) Euclid steps.
// Reset clears the sequencer and handshakes; the result register holds until taken.
// A new word is accepted while a result waits; a finished item holds in the done
// state until the result register is free.
`default_nettype none
module extended_gcd_bezout_unit #(
	parameter int OPERAND_WIDTH = egcd_pkg::DefOperandWidth
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire egcd_pkg::egcd_in_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output egcd_pkg::egcd_out_t       out_data
);
	import egcd_pkg::*;
	localparam int W  = OPERAND_WIDTH;
	localparam int OW = OPERAND_WIDTH - 1;
	localparam int SW = $clog2(MaxSteps + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_DIVW = 3'd2;
	localparam logic [2:0] ST_MAC  = 3'd3;
	localparam logic [2:0] ST_MACW = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]    state_q;
	logic [SW-1:0] step_q;
	logic [OW-1:0] dvs_q, dvd_q;
	logic [W-1:0]  ex_q, ey_q, cx_q, cy_q;
	logic          div_start, mac_start, div_done, mac_done, mac_done_y;
	logic [OW-1:0] quo, rem;
	logic [W-1:0]  nx, ny;
	logic          accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign div_start = (state_q == ST_DIV);
	assign mac_start = (state_q == ST_MAC);

	egcd_divider #(.W(OW)) u_div (
		.clk, .arst_n, .start(div_start), .dividend(dvd_q), .divisor(dvs_q),
		.done(div_done), .quotient(quo), .remainder(rem)
	);
	egcd_mac #(.W(W), .QW(OW)) u_mac_x (
		.clk, .arst_n, .start(mac_start), .c_in(cx_q), .e_in(ex_q), .q_in(quo),
		.done(mac_done), .result(nx)
	);
	egcd_mac #(.W(W), .QW(OW)) u_mac_y (
		.clk, .arst_n, .start(mac_start), .c_in(cy_q), .e_in(ey_q), .q_in(quo),
		.done(mac_done_y), .result(ny)
	);

	function automatic logic [CoefWidth-1:0] sext(input logic [W-1:0] v);
		return CoefWidth'(signed'(v));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
			step_q    <= '0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (accept) begin
					step_q  <= '0;
					state_q <= (in_data.first_operand[OW-1:0] == '0) ? ST_DONE : ST_DIV;
				end
				ST_DIV:  state_q <= ST_DIVW;
				ST_DIVW: if (div_done) begin
					if (rem == '0 || step_q == SW'(MaxSteps))
						state_q <= ST_DONE;
					else
						state_q <= ST_MAC;
				end
				ST_MAC:  state_q <= ST_MACW;
				ST_MACW: if (mac_done) begin
					step_q  <= step_q + 1'b1;
					state_q <= (step_q + 1'b1 == SW'(MaxSteps)) ? ST_DONE : ST_DIV;
				end
				ST_DONE: if (!out_valid) begin
					out_valid <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dvs_q <= in_data.first_operand[OW-1:0];
			dvd_q <= in_data.second_operand[OW-1:0];
			ex_q  <= W'(1);
			ey_q  <= '0;
			cx_q  <= '0;
			cy_q  <= W'(1);
		end else if (state_q == ST_MACW && mac_done) begin
			cx_q  <= ex_q;
			cy_q  <= ey_q;
			ex_q  <= nx;
			ey_q  <= ny;
			dvd_q <= dvs_q;
			dvs_q <= rem;
		end
		if (state_q == ST_DONE && !out_valid) begin
			if (dvs_q == '0) begin
				out_data.coeff_first        <= '0;
				out_data.coeff_second       <= '0;
				out_data.zero_divisor_error <= 1'b1;
			end else begin
				out_data.coeff_first        <= sext(ex_q);
				out_data.coeff_second       <= sext(ey_q);
				out_data.zero_divisor_error <= 1'b0;
			end
		end
	end

	a_macs_sync: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done == mac_done_y) else $error("coefficient units out of step");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("ready while busy");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !out_valid) |=> out_valid) else $error("result not posted");
endmodule
`default_nettype wire

// ===== src/egcd_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module egcd_divider #(
	parameter int W = 63
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      quotient,
	output logic [W-1:0]      remainder
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0]  quo_q, dsr_q;
	logic [W-1:0]  rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W:0]    shifted;
	logic [W:0]    diff;

	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// partial remainder stays below the divisor, so W bits hold it
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

// ===== src/egcd_mac.sv =====
// Bit-serial multiply-subtract: result = c - q*e, modulo 2^W, one q bit per cycle.
`default_nettype none
module egcd_mac #(
	parameter int W  = 64,
	parameter int QW = 63
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [W-1:0]  c_in,
	input  wire logic [W-1:0]  e_in,
	input  wire logic [QW-1:0] q_in,
	output logic               done,
	output logic [W-1:0]       result
);
	localparam int CW = $clog2(QW + 1);
	logic [W-1:0]  acc_q, e_q;
	logic [QW-1:0] q_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// shift-and-subtract: e doubles each cycle while q shifts out LSB first
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= c_in;
			e_q   <= e_in;
			q_q   <= q_in;
		end else if (busy_q) begin
			if (q_q[0])
				acc_q <= acc_q - e_q;
			e_q <= {e_q[W-2:0], 1'b0};
			q_q <= q_q >> 1;
		end
	end

	assign result = acc_q;
endmodule
`default_nettype wire

// ===== tb/sv/extended_gcd_bezout_unit_tb.sv =====
// Self-checking testbench for the extended gcd unit: directed corners plus random operand pairs.
`default_nettype none
module extended_gcd_bezout_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import egcd_pkg::*;

	localparam logic [OpWidth-1:0] OpMax = {OpWidth{1'b1}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	egcd_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	egcd_out_t out_data;

	egcd_out_t bezout_q[$];
	int mismatch_count = 0;
	int words_sent = 0;
	int words_checked = 0;
	int error_words = 0;
	int burst_left = 0;

	extended_gcd_bezout_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #10 clk = ~clk;

	// Euclid with truncating division; coefficients wrap at 64 bits
	function automatic egcd_out_t bezout_of(logic [OpWidth-1:0] a, logic [OpWidth-1:0] b);
		logic [CoefWidth-1:0] dvs, dvd, q, r, ex, ey, cx, cy, nx, ny;
		egcd_out_t res;
		dvs = {1'b0, a};
		dvd = {1'b0, b};
		ex = 64'd1; ey = 64'd0; cx = 64'd0; cy = 64'd1;
		res = '0;
		if (dvs == 0) begin
			res.zero_divisor_error = 1'b1;
			return res;
		end
		for (int step = 0; step < MaxSteps; step++) begin
			q = dvd / dvs;
			r = dvd % dvs;
			if (r == 0)
				break;
			nx = cx - q * ex;
			ny = cy - q * ey;
			cx = ex; cy = ey;
			ex = nx; ey = ny;
			dvd = dvs;
			dvs = r;
		end
		res.coeff_first = ex;
		res.coeff_second = ey;
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [CoefWidth-1:0] got,
			logic [CoefWidth-1:0] want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// sender: bursts of back-to-back words, most bursts separated by random gaps
	task automatic send_word(logic [OpWidth-1:0] a, logic [OpWidth-1:0] b);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 6);
			if ($urandom_range(0, 3) != 0) begin
				in_valid = 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end
		end
		burst_left--;
		in_data.first_operand = a;
		in_data.second_operand = b;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		bezout_q.insert(bezout_q.size(), bezout_of(a, b));
		words_sent++;
		@(negedge clk);
	endtask

	// receiver: alternating phases of always-ready and random stalls
	always @(negedge clk) begin
		if ((longint'($realtime) / 20000) % 2 == 0)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(0, 2) != 0);
	end

	always @(posedge clk) begin
		egcd_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (bezout_q.size() == 0) begin
				report_mismatch("unexpected word", out_data.coeff_first, '0);
			end else begin
				want = bezout_q.pop_front();
				words_checked++;
				if (want.zero_divisor_error)
					error_words++;
				if (out_data.coeff_first !== want.coeff_first)
					report_mismatch("coeff_first", out_data.coeff_first, want.coeff_first);
				if (out_data.coeff_second !== want.coeff_second)
					report_mismatch("coeff_second", out_data.coeff_second, want.coeff_second);
				if (out_data.zero_divisor_error !== want.zero_divisor_error)
					report_mismatch("zero_divisor_error",
						64'(out_data.zero_divisor_error), 64'(want.zero_divisor_error));
			end
		end
	end

	function automatic logic [OpWidth-1:0] rand_op();
		return OpWidth'({$urandom(), $urandom()} >> $urandom_range(0, 62));
	endfunction

	task automatic test_corners();
		send_word('0, '0);
		send_word('0, OpMax);
		send_word(OpMax, '0);
		send_word(63'd1, 63'd1);
		send_word(OpMax, OpMax);
		send_word(OpMax, 63'd1);
		send_word(63'd1, OpMax);
		send_word(63'd3, 63'd12);
		send_word(63'd12, 63'd3);
		send_word(63'd240, 63'd46);
		send_word(OpMax, OpMax - 1);
		send_word(OpMax - 1, OpMax);
		send_word(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555);
	endtask

	// consecutive Fibonacci numbers give the longest Euclid chain
	task automatic test_longest_chain();
		logic [OpWidth-1:0] f0, f1, t;
		f0 = 63'd1; f1 = 63'd1;
		for (int i = 2; i < 92; i++) begin
			t = f0 + f1; f0 = f1; f1 = t;
		end
		send_word(f0, f1);
		send_word(f1, f0);
	endtask

	task automatic test_random_pairs();
		logic [OpWidth-1:0] a, b;
		for (int i = 0; i < 100; i++) begin
			a = rand_op();
			b = rand_op();
			case ($urandom_range(0, 9))
				0: a = '0;
				1: b = '0;
				2: b = a * OpWidth'($urandom_range(1, 50));
				3: begin
					a = OpWidth'($urandom_range(1, 300));
					b = OpWidth'($urandom_range(0, 300));
				end
				default: ;
			endcase
			send_word(a, b);
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_corners();
		test_longest_chain();
		test_random_pairs();
		in_valid = 1'b0;
		while (bezout_q.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		$display("Sent %0d operand pairs, checked %0d results (%0d with zero first operand).",
			words_sent, words_checked, error_words);
		if (mismatch_count == 0 && bezout_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#100ms;
		$display("Timeout with %0d results outstanding", bezout_q.size());
		$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
src/egcd_pkg.sv
src/egcd_divider.sv
src/egcd_mac.sv
src/extended_gcd_bezout_unit.sv
tb/sv/extended_gcd_bezout_unit_tb.sv
